// ===== hw/rtl/pls_pkg.sv =====
package pls_pkg;

  localparam int CAPACITY = 256;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int POS_W    = 9;
  localparam int LEN_W    = 9;
  localparam int DATA_W   = 32;
  localparam int CMP_W    = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [AW-1:0]            addr_t;
  typedef logic [CW-1:0]            count_t;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_MODIFY = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_REMOVE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_SHIFT,
    ST_PLACE
  } state_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    addr_t raddr;
  } mem_req_t;

endpackage

// ===== hw/rtl/positional_list_store.sv =====
// Ordered list of up to CAPACITY signed 32-bit values, addressed by 1-based
// position. An item (in_action, in_position, in_value) is taken at a rising
// edge with start high and busy low. Actions: read, modify, insert before
// position, remove. Each item returns exactly one result, strobed by
// out_valid for a single cycle: out_ok, out_read_value (zero unless a good
// read) and out_length after the action. There is no backpressure on the
// result side; the receiver must take the result in the strobe cycle.
// Rejected items, modifies, appending inserts and removes of the last entry
// finish without leaving the idle state; a read waits in a read-wait state
// for one synchronous RAM read. Inserts and removes elsewhere move each
// later entry by one slot, one RAM read-and-write per cycle, in a shift
// state; an insert then writes the new value in a place state.
// busy is high only in the read-wait, shift or place state, so items that
// finish in idle never raise it; it drops as the result is issued, and the
// next item may be started in the strobe cycle.
// Synchronous reset (rst_n low) empties the list; RAM contents are not
// cleared and are only read where an earlier insert wrote them.
module positional_list_store
  import pls_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic [POS_W-1:0]   in_position,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic               out_ok,
  output logic signed [31:0] out_read_value,
  output logic [LEN_W-1:0]   out_length
);

  mem_req_t mem_req;
  data_t    mem_rdata;

  pls_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_read_value (out_read_value),
    .out_length     (out_length),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata)
  );

  pls_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

// ===== hw/rtl/pls_mem.sv =====
module pls_mem
  import pls_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output data_t    rdata
);

  data_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== hw/rtl/pls_ctrl.sv =====
module pls_ctrl
  import pls_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic [POS_W-1:0]   in_position,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic               out_ok,
  output logic signed [31:0] out_read_value,
  output logic [LEN_W-1:0]   out_length,
  output mem_req_t           mem_req,
  input  data_t              mem_rdata
);

  state_t  state_r, state_nxt;
  count_t  count_r, count_nxt;
  addr_t   ptr_r, ptr_nxt;
  addr_t   idx_r, idx_nxt;
  action_t act_r, act_nxt;
  data_t   val_r, val_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    out_ok_r, out_ok_nxt;
  data_t   out_rd_r, out_rd_nxt;
  logic [LEN_W-1:0] out_len_r, out_len_nxt;

  action_t          act_in;
  logic [CMP_W-1:0] pos_w, cnt_w, idx_w;
  count_t           cnt_m1;
  logic             pos_ok, pos_ok_ins;

  assign act_in     = action_t'(in_action);
  assign pos_w      = CMP_W'(in_position);
  assign cnt_w      = CMP_W'(count_r);
  assign idx_w      = pos_w - CMP_W'(1);
  assign cnt_m1     = count_r - CW'(1);
  assign pos_ok     = (pos_w != '0) && (pos_w <= cnt_w);
  assign pos_ok_ins = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1)) &&
                      (cnt_w < CMP_W'(CAPACITY));

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    idx_nxt       = idx_r;
    act_nxt       = act_r;
    val_nxt       = val_r;
    out_valid_nxt = 1'b0;
    out_ok_nxt    = 1'b0;
    out_rd_nxt    = '0;
    out_len_nxt   = LEN_W'(count_r);
    mem_req       = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt = act_in;
          val_nxt = in_value;
          idx_nxt = idx_w[AW-1:0];
          case (act_in)
            ACT_READ: begin
              if (pos_ok) begin
                mem_req.raddr = idx_w[AW-1:0];
                state_nxt     = ST_RDWAIT;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            ACT_MODIFY: begin
              out_valid_nxt = 1'b1;
              if (pos_ok) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_w[AW-1:0];
                mem_req.wdata = in_value;
                out_ok_nxt    = 1'b1;
              end
            end
            ACT_INSERT: begin
              if (!pos_ok_ins) begin
                out_valid_nxt = 1'b1;
              end else if (pos_w == cnt_w + CMP_W'(1)) begin
                // append: no entries to move
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_w[AW-1:0];
                mem_req.wdata = in_value;
                count_nxt     = count_r + CW'(1);
                out_valid_nxt = 1'b1;
                out_ok_nxt    = 1'b1;
                out_len_nxt   = LEN_W'(count_nxt);
              end else begin
                // move tail up one slot, starting at the last entry
                mem_req.raddr = cnt_m1[AW-1:0];
                ptr_nxt       = cnt_m1[AW-1:0];
                state_nxt     = ST_SHIFT;
              end
            end
            ACT_REMOVE: begin
              if (!pos_ok) begin
                out_valid_nxt = 1'b1;
              end else if (pos_w == cnt_w) begin
                count_nxt     = cnt_m1;
                out_valid_nxt = 1'b1;
                out_ok_nxt    = 1'b1;
                out_len_nxt   = LEN_W'(count_nxt);
              end else begin
                // move tail down one slot, starting after the removed entry
                mem_req.raddr = pos_w[AW-1:0];
                ptr_nxt       = pos_w[AW-1:0];
                state_nxt     = ST_SHIFT;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        out_valid_nxt = 1'b1;
        out_ok_nxt    = 1'b1;
        out_rd_nxt    = mem_rdata;
        state_nxt     = ST_IDLE;
      end
      ST_SHIFT: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = mem_rdata;
        if (act_r == ACT_INSERT) begin
          mem_req.waddr = ptr_r + AW'(1);
          if (ptr_r == idx_r) begin
            state_nxt = ST_PLACE;
          end else begin
            mem_req.raddr = ptr_r - AW'(1);
            ptr_nxt       = ptr_r - AW'(1);
          end
        end else begin
          mem_req.waddr = ptr_r - AW'(1);
          if (ptr_r == cnt_m1[AW-1:0]) begin
            count_nxt     = cnt_m1;
            out_valid_nxt = 1'b1;
            out_ok_nxt    = 1'b1;
            out_len_nxt   = LEN_W'(count_nxt);
            state_nxt     = ST_IDLE;
          end else begin
            mem_req.raddr = ptr_r + AW'(1);
            ptr_nxt       = ptr_r + AW'(1);
          end
        end
      end
      ST_PLACE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = val_r;
        count_nxt     = count_r + CW'(1);
        out_valid_nxt = 1'b1;
        out_ok_nxt    = 1'b1;
        out_len_nxt   = LEN_W'(count_nxt);
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    idx_r     <= idx_nxt;
    act_r     <= act_nxt;
    val_r     <= val_nxt;
    out_ok_r  <= out_ok_nxt;
    out_rd_r  <= out_rd_nxt;
    out_len_r <= out_len_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_rd_r;
  assign out_length     = out_len_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)) ||
             (count_r == $past(count_r) - CW'(1)))
    else $error("element count moved by more than one");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_rd_r == '0))
    else $error("rejected transfer carries nonzero read value");

  a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && state_nxt == ST_SHIFT) |-> (mem_req.waddr != mem_req.raddr))
    else $error("shift writes the entry it reads");

  a_count_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    (count_nxt != count_r) |-> out_valid_nxt)
    else $error("length changed without a result");
`endif

endmodule
